FILE: rtl/sbff_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbff_pkg
// Shared types and constants for the seven-bit flag framer.
// ----------------------------------------------------------------------------
package sbff_pkg;

    localparam logic [7:0] START_BYTE  = 8'h00;
    localparam logic [7:0] END_BYTE    = 8'h02;
    localparam int         GROUP_BITS  = 7;
    localparam int         DATA_BITS   = 8;
    localparam int         MAX_BEATS   = 4;
    localparam logic [2:0] MAX_PENDING = 3'd6;

    typedef struct packed {
        logic [MAX_BEATS-1:0][7:0] bytes;
        logic [2:0]                count;
        logic                      has_end;
    } burst_t;

endpackage
`default_nettype wire

FILE: rtl/seven_bit_flag_framer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// seven_bit_flag_framer
// Frames a byte message: start byte, data packed seven bits per byte with
// bit 0 set, padded tail, end byte.
// ----------------------------------------------------------------------------
// Each accepted input byte produces one to four output beats, which leave
// the result register one per cycle while m_ready is high; the next input
// byte is taken in the same cycle as the final beat of the previous one,
// so a new input byte waits until every beat of the last one has gone out
// through the single output port. The first byte of a message adds a start
// beat 0x00; the byte marked last adds a padded partial beat if bits remain
// and the end beat 0x02 with m_out_last high.
module seven_bit_flag_framer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_data_byte,
    input  wire logic       s_last_byte,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_out_last
);
    import sbff_pkg::*;

    burst_t burst;
    logic   load;

    assign load = s_valid && s_ready;

    sbff_packer u_packer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .burst     (burst)
    );

    sbff_beat_buf u_beat_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (load),
        .burst      (burst),
        .can_load   (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    a_last_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_last) |-> (m_out_byte == END_BYTE))
        else $error("frame close beat is not the end byte");

    a_load_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> m_valid)
        else $error("accepted byte produced no beat");
`endif

endmodule
`default_nettype wire

FILE: rtl/sbff_packer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbff_packer
// Holds the pending bit remainder and frame state, and forms the output
// beats caused by one input byte.
// ----------------------------------------------------------------------------
module sbff_packer (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire logic [7:0]     data_byte,
    input  wire logic           last_byte,
    output sbff_pkg::burst_t    burst
);
    import sbff_pkg::*;

    logic [6:0]  pending_bits_reg,  pending_bits_next;
    logic [2:0]  pending_count_reg, pending_count_next;
    logic        in_frame_reg,      in_frame_next;

    logic [2:0]  cnt;
    logic [14:0] acc;
    logic [3:0]  total;
    logic [3:0]  sh1;
    logic [3:0]  sh2;
    logic [14:0] shift1;
    logic [14:0] shift2;
    logic [6:0]  grp1;
    logic [6:0]  grp2;
    logic        two_groups;
    logic [2:0]  rem_cnt;
    logic [14:0] rem_wide;
    logic [6:0]  rem_bits;
    logic [2:0]  pad_cnt;
    logic [7:0]  pad_ones;
    logic [6:0]  pad_grp;
    logic [2:0]  n;

    always_comb begin
        cnt        = (pending_count_reg > MAX_PENDING) ? MAX_PENDING : pending_count_reg;
        acc        = {pending_bits_reg, data_byte};
        total      = {1'b0, cnt} + 4'(DATA_BITS);
        sh1        = total - 4'(GROUP_BITS);
        sh2        = (total >= 4'(2 * GROUP_BITS)) ? total - 4'(2 * GROUP_BITS) : 4'd0;
        shift1     = acc >> sh1;
        shift2     = acc >> sh2;
        grp1       = shift1[6:0];
        grp2       = shift2[6:0];
        two_groups = (total >= 4'(2 * GROUP_BITS));
        rem_cnt    = two_groups ? 3'(sh2) : 3'(sh1);
        rem_wide   = acc & ((15'd1 << rem_cnt) - 15'd1);
        rem_bits   = rem_wide[6:0];
        pad_cnt    = 3'(GROUP_BITS) - rem_cnt;
        pad_ones   = (8'd1 << pad_cnt) - 8'd1;
        pad_grp    = (rem_bits << pad_cnt) | pad_ones[6:0];

        burst = '0;
        n     = 3'd0;
        if (!in_frame_reg) begin
            burst.bytes[n[1:0]] = START_BYTE;
            n = n + 3'd1;
        end
        burst.bytes[n[1:0]] = {grp1, 1'b1};
        n = n + 3'd1;
        if (two_groups) begin
            burst.bytes[n[1:0]] = {grp2, 1'b1};
            n = n + 3'd1;
        end
        if (last_byte) begin
            if (rem_cnt != 3'd0) begin
                burst.bytes[n[1:0]] = {pad_grp, 1'b1};
                n = n + 3'd1;
            end
            burst.bytes[n[1:0]] = END_BYTE;
            n = n + 3'd1;
        end
        burst.count   = n;
        burst.has_end = last_byte;

        if (last_byte) begin
            pending_bits_next  = '0;
            pending_count_next = '0;
            in_frame_next      = 1'b0;
        end else begin
            pending_bits_next  = rem_bits;
            pending_count_next = rem_cnt;
            in_frame_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_bits_reg  <= '0;
            pending_count_reg <= '0;
            in_frame_reg      <= 1'b0;
        end else if (load) begin
            pending_bits_reg  <= pending_bits_next;
            pending_count_reg <= pending_count_next;
            in_frame_reg      <= in_frame_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sbff_beat_buf.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sbff_beat_buf
// Result register: holds one burst of up to four beats and sends them out
// one per cycle while m_ready is high.
// ----------------------------------------------------------------------------
module sbff_beat_buf (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           load,
    input  wire sbff_pkg::burst_t burst,
    output logic                can_load,
    output logic                m_valid,
    input  wire logic           m_ready,
    output logic [7:0]          m_out_byte,
    output logic                m_out_last
);
    import sbff_pkg::*;

    logic [MAX_BEATS-1:0][7:0] bytes_reg;
    logic [2:0]                count_reg;
    logic                      has_end_reg;
    logic [1:0]                idx_reg;
    logic                      valid_reg;
    logic                      final_beat;
    logic                      beat_done;

    assign final_beat = ({1'b0, idx_reg} == (count_reg - 3'd1));
    assign beat_done  = valid_reg && m_ready;
    assign can_load   = !valid_reg || (beat_done && final_beat);
    assign m_valid    = valid_reg;
    assign m_out_byte = bytes_reg[idx_reg];
    assign m_out_last = has_end_reg && final_beat;

    always_ff @(posedge aclk) begin
        if (load) begin
            bytes_reg   <= burst.bytes;
            count_reg   <= burst.count;
            has_end_reg <= burst.has_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
        end else if (beat_done) begin
            if (final_beat) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

FILE: tb/tb_seven_bit_flag_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_bit_flag_framer
// Self-checking testbench for the seven-bit flag framer. Messages of random
// length and content are sent under several sender and receiver idle
// patterns, including a long output hold-off that fills the block. A
// predictor frames each accepted byte, and every output beat is compared
// with the oldest predicted beat.
// ----------------------------------------------------------------------------
module tb_seven_bit_flag_framer;
    import sbff_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 12;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int DRAIN_CYCLES   = 16;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } frame_beat_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_data_byte;
    logic       s_last_byte;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    frame_beat_t beat_q[$];
    logic [6:0]  held_bits;
    int unsigned held_cnt;
    logic        frame_open;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_left;
    int unsigned items_sent;
    int unsigned fail_count;
    int unsigned cycle_count;

    seven_bit_flag_framer DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Frame one accepted byte and queue the beats it produces.
    function automatic void frame_byte(input logic [7:0] d, input logic l);
        logic [14:0] acc;
        logic [6:0]  grp;
        int unsigned cnt;
        cnt = held_cnt;
        if (!frame_open) begin
            beat_q.push_back({START_BYTE, 1'b0});
            frame_open = 1'b1;
        end
        acc = {held_bits, d};
        cnt += DATA_BITS;
        while (cnt >= GROUP_BITS) begin
            grp = 7'(acc >> (cnt - GROUP_BITS));
            beat_q.push_back({grp, 1'b1, 1'b0});
            cnt -= GROUP_BITS;
        end
        acc &= (15'd1 << cnt) - 15'd1;
        if (l) begin
            if (cnt > 0) begin
                grp = 7'((acc << (GROUP_BITS - cnt))
                         | ((15'd1 << (GROUP_BITS - cnt)) - 15'd1));
                beat_q.push_back({grp, 1'b1, 1'b0});
            end
            beat_q.push_back({END_BYTE, 1'b1});
            held_bits  = '0;
            held_cnt   = 0;
            frame_open = 1'b0;
        end else begin
            held_bits = acc[6:0];
            held_cnt  = cnt;
        end
    endfunction

    // Receiver: random stalls, or a counted hold-off when one is requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        frame_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (beat_q.size() == 0) begin
                $error("unexpected beat: out_byte %0h out_last %0b", m_out_byte, m_out_last);
                fail_count++;
            end else begin
                want = beat_q.pop_front();
                if (m_out_byte !== want.out_byte) begin
                    $error("out_byte: expected %0h, actual %0h", want.out_byte, m_out_byte);
                    fail_count++;
                end
                if (m_out_last !== want.out_last) begin
                    $error("out_last: expected %0b, actual %0b", want.out_last, m_out_last);
                    fail_count++;
                end
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] d, input logic l);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(negedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid     <= 1'b1;
        s_data_byte <= d;
        s_last_byte <= l;
        do @(posedge aclk); while (!s_ready);
        frame_byte(d, l);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_message(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(255)), i == len - 1);
        end
    endtask

    task automatic test_directed_frames();
        logic [7:0] fill_msg[7];
        fill_msg = '{8'h80, 8'h01, 8'hAA, 8'h55, 8'hFF, 8'h00, 8'h7F};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // one-byte frames at both data extremes
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // seven bytes leave nothing held: no pad beat
        foreach (fill_msg[i]) send_byte(fill_msg[i], i == 6);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h01, 1'b1);
        // six bytes leave six bits held: one pad bit
        send_message(6);
        send_message(3);
    endtask

    task automatic test_random_frames(input int unsigned idle, input int unsigned stall,
                                      input int unsigned n_items);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned len;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(9);
            if (pick < 2)       len = 7 * $urandom_range(1, 3);
            else if (pick == 9) len = $urandom_range(17, 40);
            else                len = $urandom_range(1, 12);
            send_message(len);
        end
    endtask

    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 250;
        send_message(30);
        send_message(5);
    endtask

    task automatic wait_drain();
        while (beat_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data_byte    = '0;
        s_last_byte    = 1'b0;
        m_ready        = 1'b0;
        held_bits      = '0;
        held_cnt       = 0;
        frame_open     = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        items_sent     = 0;
        fail_count     = 0;
        cycle_count    = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_frames();
        test_random_frames(0, 0, 75);
        test_random_frames(74, 0, 75);
        test_random_frames(0, 74, 75);
        test_output_holdoff();
        test_random_frames(6, 6, 75);

        s_valid <= 1'b0;
        wait_drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
